### rtl/lru_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the LRU page replacement block.
// No dependencies; imported by the controller, datapath and top level.
package lru_pkg;

  localparam int FRAMES     = 4;
  localparam int PAGE_BITS  = 8;
  localparam int FRAME_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_BITS  = FRAME_BITS;
  localparam int LIMIT_BITS = RANK_BITS + 1;
  localparam int PAGE_W     = 8;
  localparam int USED_W     = 2;
  localparam int COUNT_W    = 16;

  typedef logic [PAGE_BITS-1:0]  tag_t;
  typedef logic [RANK_BITS-1:0]  rank_t;
  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [COUNT_W-1:0]    count_t;

  typedef struct packed {
    logic load_req;
    logic lookup;
  } lru_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_HOLD   = 4'b0100,
    ST_PEND   = 4'b1000
  } lru_state_t;

endpackage

### rtl/lru_ctrl.sv
`timescale 1ns / 1ps
// Controller for the LRU block: sequences capture, lookup and response.
// Depends on lru_pkg for the state encoding and the command struct.
module lru_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output lru_pkg::lru_cmd_t cmd
);
  import lru_pkg::*;

  lru_state_t state;
  lru_state_t state_next;
  logic       req_beat;
  logic       rsp_beat;

  assign req_beat = req_valid && !req_stall;
  assign rsp_beat = rsp_valid && !rsp_stall;

  always_comb begin
    req_stall    = 1'b1;
    rsp_valid    = 1'b0;
    cmd.load_req = 1'b0;
    cmd.lookup   = 1'b0;
    state_next   = state;
    case (state)
      ST_IDLE: begin
        req_stall    = 1'b0;
        cmd.load_req = req_valid;
        if (req_valid) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        req_stall    = 1'b0;
        rsp_valid    = 1'b1;
        cmd.load_req = req_valid;
        if (rsp_beat && req_beat) state_next = ST_LOOKUP;
        else if (rsp_beat)        state_next = ST_IDLE;
        else if (req_beat)        state_next = ST_PEND;
      end
      ST_PEND: begin
        rsp_valid = 1'b1;
        if (rsp_beat) state_next = ST_LOOKUP;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/lru_datapath.sv
`timescale 1ns / 1ps
// Datapath for the LRU block: frame tags, valid bits, ranks, fault counter
// and the response register. Depends on lru_pkg; driven by lru_ctrl commands.
module lru_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  lru_pkg::lru_cmd_t             cmd,
  input  logic [lru_pkg::PAGE_W-1:0]    page,
  output logic                          hit,
  output logic [lru_pkg::USED_W-1:0]    frame_used,
  output logic                          evicted_valid,
  output logic [lru_pkg::PAGE_W-1:0]    evicted_page,
  output logic [lru_pkg::COUNT_W-1:0]   fault_count
);
  import lru_pkg::*;

  tag_t        page_q;
  tag_t        frame_tags [FRAMES];
  logic        frame_valid [FRAMES];
  rank_t       recency_rank [FRAMES];
  count_t      miss_total;

  logic        is_hit;
  logic        found_empty;
  frame_t      hit_idx;
  frame_t      empty_idx;
  frame_t      victim_idx;
  frame_t      sel;
  logic [LIMIT_BITS-1:0] limit;
  count_t      miss_next;

  always_comb begin
    is_hit      = 1'b0;
    hit_idx     = '0;
    found_empty = 1'b0;
    empty_idx   = '0;
    victim_idx  = '0;
    for (int f = FRAMES - 1; f >= 0; f--) begin
      if (frame_valid[f] && frame_tags[f] == page_q) begin
        is_hit  = 1'b1;
        hit_idx = FRAME_BITS'(f);
      end
      if (!frame_valid[f]) begin
        found_empty = 1'b1;
        empty_idx   = FRAME_BITS'(f);
      end
    end
    for (int f = 1; f < FRAMES; f++) begin
      if (recency_rank[f] > recency_rank[victim_idx]) victim_idx = FRAME_BITS'(f);
    end
    if (is_hit)           sel = hit_idx;
    else if (found_empty) sel = empty_idx;
    else                  sel = victim_idx;
    limit = is_hit ? {1'b0, recency_rank[hit_idx]} : LIMIT_BITS'(FRAMES);
    miss_next = (miss_total == '1) ? miss_total : miss_total + COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) page_q <= PAGE_BITS'(page);
    if (cmd.lookup) begin
      if (!is_hit) frame_tags[sel] <= page_q;
      hit           <= is_hit;
      frame_used    <= USED_W'(sel);
      evicted_valid <= !is_hit && !found_empty;
      evicted_page  <= (!is_hit && !found_empty) ? PAGE_W'(frame_tags[sel]) : '0;
      fault_count   <= is_hit ? miss_total : miss_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < FRAMES; f++) begin
        frame_valid[f]  <= 1'b0;
        recency_rank[f] <= '0;
      end
      miss_total <= '0;
    end else if (cmd.lookup) begin
      for (int g = 0; g < FRAMES; g++) begin
        if (FRAME_BITS'(g) == sel) begin
          recency_rank[g] <= '0;
        end else if (frame_valid[g] && {1'b0, recency_rank[g]} < limit) begin
          recency_rank[g] <= recency_rank[g] + RANK_BITS'(1);
        end
      end
      if (!is_hit) begin
        frame_valid[sel] <= 1'b1;
        miss_total       <= miss_next;
      end
    end
  end

endmodule

### rtl/lru_page_replacement.sv
`timescale 1ns / 1ps
// Top level of the LRU page replacement block: controller plus datapath.
// Depends on lru_pkg, lru_ctrl and lru_datapath.
//
//   channel  handshake             payload
//   req      req_valid/req_stall   page[7:0]
//   rsp      rsp_valid/rsp_stall   hit, frame_used[1:0], evicted_valid,
//                                  evicted_page[7:0], fault_count[15:0]
//
// A reference from an idle block passes through capture, one lookup/update
// state over all frames, then the response register. A new beat is taken
// while a response waits, so the sustained rate is set by the single
// lookup/update state. Reset clears valid bits, ranks and the fault
// counter. A stalled response holds.
module lru_page_replacement (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [lru_pkg::PAGE_W-1:0]  page,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic                        hit,
  output logic [lru_pkg::USED_W-1:0]  frame_used,
  output logic                        evicted_valid,
  output logic [lru_pkg::PAGE_W-1:0]  evicted_page,
  output logic [lru_pkg::COUNT_W-1:0] fault_count
);
  import lru_pkg::*;

  lru_cmd_t cmd;

  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  lru_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .page          (page),
    .hit           (hit),
    .frame_used    (frame_used),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count)
  );

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_page_replacement: a queue-fed driver, a monitor and an
// in-bench LRU predictor with its own frame tags, ranks and saturating miss count.
// Depends on lru_pkg and the lru_page_replacement RTL.
module tb;
  import lru_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic        hit;
    logic [1:0]  frame;
    logic        ev_valid;
    logic [7:0]  ev_page;
    logic [15:0] faults;
  } page_outcome_t;

  typedef enum int {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_mode_e;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic [PAGE_W-1:0]    page = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  logic                 hit;
  logic [USED_W-1:0]    frame_used;
  logic                 evicted_valid;
  logic [PAGE_W-1:0]    evicted_page;
  logic [COUNT_W-1:0]   fault_count;

  tag_t          pend_q[$];
  page_outcome_t outcome_q[$];
  int            mismatches = 0;

  tag_t   frm_tag[FRAMES];
  bit     frm_live[FRAMES] = '{default: 1'b0};
  rank_t  frm_age[FRAMES] = '{default: '0};
  count_t miss_cnt = '0;

  lru_page_replacement u_dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .page         (page),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .hit          (hit),
    .frame_used   (frame_used),
    .evicted_valid(evicted_valid),
    .evicted_page (evicted_page),
    .fault_count  (fault_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic page_outcome_t lookup_page(tag_t pg);
    page_outcome_t o;
    int  f;
    int  sel;
    int  lim;
    bit  found;
    o = '0;
    sel = 0;
    found = 1'b0;
    for (f = 0; f < FRAMES; f++) begin
      if (!found && frm_live[f] && frm_tag[f] == pg) begin
        sel = f;
        found = 1'b1;
      end
    end
    if (found) begin
      o.hit = 1'b1;
      lim = frm_age[sel];
    end else begin
      for (f = 0; f < FRAMES; f++) begin
        if (!found && !frm_live[f]) begin
          sel = f;
          found = 1'b1;
        end
      end
      if (!found) begin
        sel = 0;
        for (f = 1; f < FRAMES; f++) begin
          if (frm_age[f] > frm_age[sel]) sel = f;
        end
        o.ev_valid = 1'b1;
        o.ev_page = frm_tag[sel];
      end
      frm_tag[sel] = pg;
      frm_live[sel] = 1'b1;
      lim = FRAMES;
      if (miss_cnt != '1) miss_cnt = miss_cnt + 1'b1;
    end
    // age every live frame more recent than the touched one
    for (f = 0; f < FRAMES; f++) begin
      if (f != sel && frm_live[f] && int'(frm_age[f]) < lim) frm_age[f] = frm_age[f] + 1'b1;
    end
    frm_age[sel] = '0;
    o.frame = sel[1:0];
    o.faults = miss_cnt;
    return o;
  endfunction

  // driver: bursts of beats separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) outcome_q.push_back(lookup_page(page));
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          req_valid <= 1'b1;
          page <= pend_q.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  rx_mode_e rx_mode = RX_OPEN;
  int       mode_left = 0;
  int       stall_period = 2;
  int       hold_left = 0;
  int       seen_rsp = 0;
  bit       held = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) seen_rsp++;
      if (!held && seen_rsp == 200) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
        stall_period = $urandom_range(2, 5);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_OPEN:     rsp_stall <= 1'b0;
          RX_SPARSE:   rsp_stall <= ($urandom_range(0, 99) < 30);
          RX_PERIODIC: rsp_stall <= (mode_left % stall_period == 0);
          default:     rsp_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    page_outcome_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (outcome_q.size() == 0) begin
        $error("response beat with no outstanding reference");
        mismatches++;
      end else begin
        want = outcome_q.pop_front();
        check_field("hit", want.hit, hit);
        check_field("frame_used", want.frame, frame_used);
        check_field("evicted_valid", want.ev_valid, evicted_valid);
        check_field("evicted_page", want.ev_page, evicted_page);
        check_field("fault_count", want.faults, fault_count);
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (pend_q.size() != 0 || outcome_q.size() != 0 || req_valid);
  endtask

  task automatic push_random(int n);
    tag_t ws[6];
    int   ws_n;
    int   k;
    ws_n = $urandom_range(3, 6);
    for (k = 0; k < 6; k++) ws[k] = tag_t'($urandom_range(0, 255));
    repeat (n) begin
      if ($urandom_range(0, 99) < 5) ws[$urandom_range(0, ws_n - 1)] = tag_t'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 80) pend_q.push_back(ws[$urandom_range(0, ws_n - 1)]);
      else pend_q.push_back(tag_t'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    tag_t directed[19];
    directed = '{8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'hFF, 8'h01, 8'h00,
                 8'hAA, 8'h55, 8'h55, 8'h55, 8'hFE, 8'h7F, 8'h80, 8'h01,
                 8'hFE, 8'h00, 8'hFF};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed[j]) pend_q.push_back(directed[j]);
    wait_drained();
    push_random(250);
    wait_drained();
    push_random(250);
    wait_drained();
    push_random(30);
    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
rtl/lru_pkg.sv
rtl/lru_ctrl.sv
rtl/lru_datapath.sv
rtl/lru_page_replacement.sv
tb/sv/tb.sv
